/* rtl/thumb_shift_logic_unit_macros.svh */
// Assertion macros for the thumb shift and logic unit.
// Define ASSERT_OFF to drop every assertion; no other dependencies.
`ifndef THUMB_SHIFT_LOGIC_UNIT_MACROS_SVH
`define THUMB_SHIFT_LOGIC_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent in this cycle implies consequent in the same cycle
`define TSLU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tslu assertion failed");
// antecedent in this cycle implies consequent in the next cycle
`define TSLU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tslu assertion failed");
`else
`define TSLU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TSLU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/tslu_pkg.sv */
// Shared types and constants for the thumb shift and logic unit.
// No dependencies; imported by every stage and the top level.
package tslu_pkg;

	localparam int WORD_W  = 32;
	localparam int FUNC_W  = 4;
	localparam int AMT_W   = 8;
	localparam int SHAMT_W = 5;

	typedef enum logic [FUNC_W-1:0] {
		OP_LSL   = 4'd0,
		OP_LSR   = 4'd1,
		OP_ASR   = 4'd2,
		OP_ROR   = 4'd3,
		OP_BIC   = 4'd4,
		OP_MVN   = 4'd5,
		OP_RSB   = 4'd6,
		OP_REV   = 4'd7,
		OP_REV16 = 4'd8,
		OP_REVSH = 4'd9,
		OP_NOP   = 4'd10
	} func_t;

	// decoded request after stage 1
	typedef struct packed {
		func_t              op;
		logic [WORD_W-1:0]  a;
		logic [WORD_W-1:0]  b;
		logic               c;
		logic               amt_zero;
		logic               amt_lt32;
		logic               amt_eq32;
		logic [SHAMT_W-1:0] k;
	} dec_t;

	// executed request after stage 2
	typedef struct packed {
		logic [WORD_W-1:0] res;
		logic              c;
	} exe_t;

endpackage

/* rtl/thumb_shift_logic_unit.sv */
// Thumb shift and logic unit: three register stages (decode, execute, flags).
// Accepts one request per cycle while out_ready does not stall the output.
// Each stage advances when its downstream slot is empty or being drained.
// arst_n asynchronously clears all stage valid bits; payload is not reset.
// Depends on tslu_pkg, tslu_decode, tslu_exec, tslu_flags and the macro header.
`include "thumb_shift_logic_unit_macros.svh"
module thumb_shift_logic_unit import tslu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [WORD_W-1:0] operand_a,
	input  logic [WORD_W-1:0] operand_b,
	input  logic              carry_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] result,
	output logic              flag_n,
	output logic              flag_z,
	output logic              flag_c
);

	logic v1;
	logic r1;
	logic v2;
	logic r2;
	dec_t dec;
	exe_t exe;

	tslu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.carry_in  (carry_in),
		.out_valid (v1),
		.out_ready (r1),
		.out_dec   (dec)
	);

	tslu_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_dec    (dec),
		.out_valid (v2),
		.out_ready (r2),
		.out_exe   (exe)
	);

	tslu_flags u_flags (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.in_exe    (exe),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.flag_n    (flag_n),
		.flag_z    (flag_z),
		.flag_c    (flag_c)
	);

	`TSLU_ASSERT_SAME(a_flag_n, clk, arst_n, out_valid, flag_n == result[WORD_W-1])
	`TSLU_ASSERT_SAME(a_flag_z, clk, arst_n, out_valid, flag_z == (result == '0))
	`TSLU_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, v1)
	`TSLU_ASSERT_NEXT(a_s2_holds, clk, arst_n, v2 && !r2, v2 && $stable(exe))

endmodule

/* rtl/tslu_decode.sv */
// Stage 1: capture the request and classify the shift amount.
// Depends on tslu_pkg.
module tslu_decode import tslu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FUNC_W-1:0]     func,
	input  logic [WORD_W-1:0]     operand_a,
	input  logic [WORD_W-1:0]     operand_b,
	input  logic                  carry_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dec_t                  out_dec
);

	logic             valid_s1;
	dec_t             dec_s1;
	logic [AMT_W-1:0] amt;

	assign amt      = operand_b[AMT_W-1:0];
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dec_s1.op       <= func_t'(func);
			dec_s1.a        <= operand_a;
			dec_s1.b        <= operand_b;
			dec_s1.c        <= carry_in;
			dec_s1.amt_zero <= (amt == '0);
			dec_s1.amt_lt32 <= (amt[AMT_W-1:SHAMT_W] == '0);
			dec_s1.amt_eq32 <= (amt == AMT_W'(WORD_W));
			dec_s1.k        <= amt[SHAMT_W-1:0];
		end
	end

	assign out_valid = valid_s1;
	assign out_dec   = dec_s1;

endmodule

/* rtl/tslu_exec.sv */
// Stage 2: barrel shifts, logic ops, negate and byte reversals with carry.
// Depends on tslu_pkg.
module tslu_exec import tslu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  dec_t in_dec,
	output logic out_valid,
	input  logic out_ready,
	output exe_t out_exe
);

	logic                 valid_s2;
	exe_t                 exe_s2;
	exe_t                 exe_d;
	logic [WORD_W:0]      lsl_w;
	logic [WORD_W:0]      lsr_w;
	logic signed [WORD_W:0] asr_w;
	logic [2*WORD_W-1:0]  ror_w;
	logic [WORD_W-1:0]    a;
	logic [WORD_W-1:0]    b;

	assign a = in_dec.a;
	assign b = in_dec.b;

	// the extra bit catches the last bit shifted out
	assign lsl_w = {1'b0, a} << in_dec.k;
	assign lsr_w = {a, 1'b0} >> in_dec.k;
	assign asr_w = $signed({a, 1'b0}) >>> in_dec.k;
	assign ror_w = {a, a} >> in_dec.k;

	always_comb begin
		exe_d.res = a;
		exe_d.c   = in_dec.c;
		unique case (in_dec.op)
			OP_LSL: begin
				if (in_dec.amt_zero) begin
					exe_d.res = a;
				end else if (in_dec.amt_lt32) begin
					exe_d.res = lsl_w[WORD_W-1:0];
					exe_d.c   = lsl_w[WORD_W];
				end else begin
					exe_d.res = '0;
					exe_d.c   = in_dec.amt_eq32 & a[0];
				end
			end
			OP_LSR: begin
				if (in_dec.amt_zero) begin
					exe_d.res = a;
				end else if (in_dec.amt_lt32) begin
					exe_d.res = lsr_w[WORD_W:1];
					exe_d.c   = lsr_w[0];
				end else begin
					exe_d.res = '0;
					exe_d.c   = in_dec.amt_eq32 & a[WORD_W-1];
				end
			end
			OP_ASR: begin
				if (in_dec.amt_zero) begin
					exe_d.res = a;
				end else if (in_dec.amt_lt32) begin
					exe_d.res = asr_w[WORD_W:1];
					exe_d.c   = asr_w[0];
				end else begin
					exe_d.res = {WORD_W{a[WORD_W-1]}};
					exe_d.c   = a[WORD_W-1];
				end
			end
			OP_ROR: begin
				exe_d.res = ror_w[WORD_W-1:0];
				if (!in_dec.amt_zero) begin
					exe_d.c = ror_w[WORD_W-1];
				end
			end
			OP_BIC: exe_d.res = a & ~b;
			OP_MVN: exe_d.res = ~b;
			OP_RSB: begin
				exe_d.res = '0 - b;
				exe_d.c   = (b == '0);
			end
			OP_REV:   exe_d.res = {b[7:0], b[15:8], b[23:16], b[31:24]};
			OP_REV16: exe_d.res = {b[23:16], b[31:24], b[7:0], b[15:8]};
			OP_REVSH: exe_d.res = {{16{b[7]}}, b[7:0], b[15:8]};
			default:  exe_d.res = a;
		endcase
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			exe_s2 <= exe_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_exe   = exe_s2;

endmodule

/* rtl/tslu_flags.sv */
// Stage 3: derive N and Z and hold the result in the output register.
// Depends on tslu_pkg.
module tslu_flags import tslu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  exe_t              in_exe,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] result,
	output logic              flag_n,
	output logic              flag_z,
	output logic              flag_c
);

	logic              valid_s3;
	logic [WORD_W-1:0] result_s3;
	logic              n_s3;
	logic              z_s3;
	logic              c_s3;

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_s3 <= in_exe.res;
			n_s3      <= in_exe.res[WORD_W-1];
			z_s3      <= (in_exe.res == '0);
			c_s3      <= in_exe.c;
		end
	end

	assign out_valid = valid_s3;
	assign result    = result_s3;
	assign flag_n    = n_s3;
	assign flag_z    = z_s3;
	assign flag_c    = c_s3;

endmodule
